// File: hdl/ttsam_pkg.sv
// Shared types, codes and reset values of the touch-to-screen absolute mapper.
`default_nettype none
package ttsam_pkg;
	localparam int COORD_BITS_DEF = 16;
	localparam int CONTACT_BITS_DEF = 8;
	localparam int CFG_IDX_W = 3;
	localparam int CFG_W = 32;

	localparam logic [CFG_IDX_W-1:0] REG_PAD_X = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_PAD_Y = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_SCR_X = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_SCR_Y = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_DESK_X = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_DESK_Y = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_CTRL = 3'd6;

	localparam logic [31:0] PAD_X_RST = 32'd190316544;
	localparam logic [31:0] PAD_Y_RST = 32'd123142144;
	localparam logic [31:0] SCR_X_RST = 32'd125829120;
	localparam logic [31:0] SCR_Y_RST = 32'd70778880;
	localparam logic [31:0] DESK_X_RST = 32'd125829120;
	localparam logic [31:0] DESK_Y_RST = 32'd70778880;
	localparam logic [4:0] CTRL_RST = 5'd6;

	localparam logic [1:0] EV_MOVE = 2'd0;
	localparam logic [1:0] EV_LEFT = 2'd1;
	localparam logic [1:0] EV_RIGHT = 2'd2;

	localparam logic [1:0] FN_NONE = 2'd0;
	localparam logic [1:0] FN_LIFT = 2'd1;
	localparam logic [1:0] FN_DOWN = 2'd2;

	localparam logic [15:0] NORM_MAX = 16'hFFFF;

	typedef struct packed {
		logic [31:0] pad_x;
		logic [31:0] pad_y;
		logic [31:0] scr_x;
		logic [31:0] scr_y;
		logic [31:0] desk_x;
		logic [31:0] desk_y;
		logic [4:0]  ctrl;
	} cfg_t;

	typedef struct packed {
		logic        move;
		logic [15:0] cl_x;
		logic [15:0] cl_y;
		logic        l_ev;
		logic        l_lvl;
		logic        r_ev;
		logic        r_lvl;
	} job_t;

	typedef struct packed {
		logic [1:0]  kind;
		logic [15:0] nx;
		logic [15:0] ny;
		logic        pressed;
		logic        last;
	} res_t;
endpackage
`default_nettype wire

// File: hdl/ttsam_fifo.sv
// Two-entry queue used between the front and back parts and at the result side.
`default_nettype none
module ttsam_fifo #(
	parameter int WIDTH = 1
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             push,
	input  wire logic [WIDTH-1:0] wdata,
	output logic                  full,
	input  wire logic             pop,
	output logic [WIDTH-1:0]      rdata,
	output logic                  empty
);
	logic [WIDTH-1:0] mem_q [2];
	logic             wp_q, rp_q;
	logic [1:0]       cnt_q;
	logic             do_push, do_pop;

	assign full = (cnt_q == 2'd2);
	assign empty = (cnt_q == 2'd0);
	assign do_push = push & ~full;
	assign do_pop = pop & ~empty;
	assign rdata = mem_q[rp_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wp_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= 1'b0;
			rp_q <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (do_push) begin
				wp_q <= ~wp_q;
			end
			if (do_pop) begin
				rp_q <= ~rp_q;
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + 2'd1;
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - 2'd1;
			end
		end
	end

`ifndef NO_ASSERTIONS
	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n) cnt_q != 2'd3)
		else $error("queue count out of range");
	a_cnt_up: assert property (@(posedge clk) disable iff (!arst_n)
		(do_push && !do_pop) |=> cnt_q == $past(cnt_q) + 2'd1)
		else $error("queue count did not rise on push");
	a_cnt_down: assert property (@(posedge clk) disable iff (!arst_n)
		(do_pop && !do_push) |=> cnt_q == $past(cnt_q) - 2'd1)
		else $error("queue count did not fall on pop");
`endif
endmodule
`default_nettype wire

// File: hdl/ttsam_front.sv
// Front part: contact lock, sample tracking, clamping and button edge decisions.
`default_nettype none
module ttsam_front #(
	parameter int COORD_BITS = ttsam_pkg::COORD_BITS_DEF,
	parameter int CONTACT_BITS = ttsam_pkg::CONTACT_BITS_DEF
) (
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire ttsam_pkg::cfg_t         cfg,
	input  wire logic                    push,
	input  wire logic [CONTACT_BITS-1:0] contact_id,
	input  wire logic                    tip_down,
	input  wire logic                    x_present,
	input  wire logic [COORD_BITS-1:0]   x_sample,
	input  wire logic                    y_present,
	input  wire logic [COORD_BITS-1:0]   y_sample,
	input  wire logic                    left_key_down,
	input  wire logic                    right_key_down,
	input  wire logic                    jfull,
	output logic                         jpush,
	output ttsam_pkg::job_t              job
);
	logic                    lock_q, lock_n;
	logic [CONTACT_BITS-1:0] lc_q, lc_n;
	logic                    xv_q, xv_n, yv_q, yv_n;
	logic [COORD_BITS-1:0]   x_q, x_n, y_q, y_n;
	logic                    left_q, right_q;
	logic                    accept, pass, act, want_l, want_r;
	logic [1:0]              fn;

	function automatic logic [15:0] clamp(input logic [31:0] raw, input logic [31:0] pad);
		logic [31:0] mn, mx;
		mn = {16'b0, pad[15:0]};
		mx = {16'b0, pad[31:16]};
		if (raw < mn) begin
			clamp = pad[15:0];
		end else if (raw > mx) begin
			clamp = pad[31:16];
		end else begin
			clamp = raw[15:0];
		end
	endfunction

	assign accept = push & ~jfull;
	assign fn = cfg.ctrl[1:0];

	always_comb begin
		lock_n = lock_q;
		lc_n = lc_q;
		if (tip_down) begin
			if (!lock_q) begin
				lock_n = 1'b1;
				lc_n = contact_id;
			end
		end else if (lock_q && lc_q == contact_id) begin
			lock_n = 1'b0;
		end
		pass = !(lock_n && lc_n != contact_id);
		xv_n = xv_q | (pass & x_present);
		yv_n = yv_q | (pass & y_present);
		x_n = (pass && x_present) ? x_sample : x_q;
		y_n = (pass && y_present) ? y_sample : y_q;
		act = pass & cfg.ctrl[4];
		if (cfg.ctrl[2]) begin
			priority if (fn == ttsam_pkg::FN_DOWN) begin
				want_l = left_key_down;
			end else if (fn == ttsam_pkg::FN_LIFT) begin
				want_l = tip_down & ~left_key_down;
			end else begin
				want_l = tip_down;
			end
		end else begin
			want_l = (fn == ttsam_pkg::FN_NONE) & tip_down;
		end
		want_r = cfg.ctrl[3] & right_key_down;
		job.move = xv_n & yv_n & tip_down;
		job.cl_x = clamp({{(32-COORD_BITS){1'b0}}, x_n}, cfg.pad_x);
		job.cl_y = clamp({{(32-COORD_BITS){1'b0}}, y_n}, cfg.pad_y);
		job.l_ev = want_l != left_q;
		job.l_lvl = want_l;
		job.r_ev = want_r != right_q;
		job.r_lvl = want_r;
	end

	assign jpush = accept & act & (job.move | job.l_ev | job.r_ev);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lock_q <= 1'b0;
			lc_q <= '0;
			xv_q <= 1'b0;
			yv_q <= 1'b0;
			x_q <= '0;
			y_q <= '0;
			left_q <= 1'b0;
			right_q <= 1'b0;
		end else if (accept) begin
			lock_q <= lock_n;
			lc_q <= lc_n;
			xv_q <= xv_n;
			yv_q <= yv_n;
			x_q <= x_n;
			y_q <= y_n;
			if (act) begin
				left_q <= want_l;
				right_q <= want_r;
			end
		end
	end
endmodule
`default_nettype wire

// File: hdl/ttsam_back.sv
// Back part: scaling and normalisation through a shared divider, then result issue.
`default_nettype none
module ttsam_back (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire ttsam_pkg::cfg_t cfg,
	input  wire logic            jempty,
	input  wire ttsam_pkg::job_t jdata,
	output logic                 jpop,
	input  wire logic            ofull,
	output logic                 opush,
	output ttsam_pkg::res_t      odata
);
	typedef enum logic [2:0] {
		S_IDLE, S_MUL, S_DSET, S_DIV, S_ADJ1, S_ADJ2, S_EMIT
	} state_t;

	state_t             st_q;
	ttsam_pkg::job_t    job_q;
	logic               axis_q, phase2_q, neg_q;
	logic               mv_p_q, l_p_q, r_p_q;
	logic signed [33:0] p_q;
	logic [15:0]        dsr_q, rem_q, nx_q, ny_q;
	logic [31:0]        div_q;
	logic [5:0]         cnt_q;
	logic signed [34:0] a_q;

	logic [31:0]        pad, scr, desk;
	logic [15:0]        cl, wdiv, dw, res_v;
	logic signed [16:0] d_s, sw_s, wdiff;
	logic signed [33:0] prod, pabs;
	logic [16:0]        rem_t;
	logic               ge;
	logic [15:0]        rem_n;
	logic [31:0]        div_n;
	logic signed [34:0] s0x, d0x, qx, a_n;
	logic signed [50:0] a51, num;
	logic [50:0]        lim;
	logic               emit_last;

	assign pad = axis_q ? cfg.pad_y : cfg.pad_x;
	assign scr = axis_q ? cfg.scr_y : cfg.scr_x;
	assign desk = axis_q ? cfg.desk_y : cfg.desk_x;
	assign cl = axis_q ? job_q.cl_y : job_q.cl_x;

	always_comb begin
		d_s = signed'({1'b0, cl}) - signed'({1'b0, pad[15:0]});
		sw_s = signed'({scr[31], scr[31:16]}) - signed'({scr[15], scr[15:0]});
		prod = d_s * sw_s;
		wdiff = signed'({1'b0, pad[31:16]}) - signed'({1'b0, pad[15:0]});
		wdiv = (wdiff <= 0) ? 16'd1 : wdiff[15:0];
		pabs = p_q[33] ? -p_q : p_q;
		rem_t = {rem_q, div_q[31]};
		ge = rem_t >= {1'b0, dsr_q};
		rem_n = ge ? 16'(rem_t - {1'b0, dsr_q}) : rem_t[15:0];
		div_n = {div_q[30:0], ge};
		s0x = {{19{scr[15]}}, scr[15:0]};
		d0x = {{19{desk[15]}}, desk[15:0]};
		qx = {3'b0, div_q};
		a_n = (neg_q ? s0x - qx : s0x + qx) - d0x;
		a51 = {{16{a_q[34]}}, a_q};
		num = (a51 <<< 16) - a51;
		dw = (desk[31] || desk[31:16] == 16'd0) ? 16'd1 : desk[31:16];
		lim = {19'b0, dw, 16'b0};
		res_v = div_n[15:0];
	end

	assign jpop = (st_q == S_IDLE) && !jempty;
	assign opush = (st_q == S_EMIT) && !ofull && (mv_p_q || l_p_q || r_p_q);

	always_comb begin
		odata.nx = 16'd0;
		odata.ny = 16'd0;
		odata.pressed = 1'b0;
		if (mv_p_q) begin
			odata.kind = ttsam_pkg::EV_MOVE;
			odata.nx = nx_q;
			odata.ny = ny_q;
			emit_last = !(l_p_q || r_p_q);
		end else if (l_p_q) begin
			odata.kind = ttsam_pkg::EV_LEFT;
			odata.pressed = job_q.l_lvl;
			emit_last = !r_p_q;
		end else begin
			odata.kind = ttsam_pkg::EV_RIGHT;
			odata.pressed = job_q.r_lvl;
			emit_last = 1'b1;
		end
		odata.last = emit_last;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= S_IDLE;
			job_q <= '0;
			mv_p_q <= 1'b0;
			l_p_q <= 1'b0;
			r_p_q <= 1'b0;
			axis_q <= 1'b0;
			phase2_q <= 1'b0;
			neg_q <= 1'b0;
			p_q <= '0;
			div_q <= '0;
			rem_q <= '0;
			dsr_q <= '0;
			nx_q <= '0;
			ny_q <= '0;
			a_q <= '0;
			cnt_q <= '0;
		end else begin
			unique case (st_q)
				S_IDLE: begin
					if (!jempty) begin
						job_q <= jdata;
						mv_p_q <= jdata.move;
						l_p_q <= jdata.l_ev;
						r_p_q <= jdata.r_ev;
						axis_q <= 1'b0;
						st_q <= jdata.move ? S_MUL : S_EMIT;
					end
				end
				S_MUL: begin
					p_q <= prod;
					neg_q <= prod[33];
					st_q <= S_DSET;
				end
				S_DSET: begin
					div_q <= pabs[31:0];
					rem_q <= 16'd0;
					dsr_q <= wdiv;
					cnt_q <= 6'd32;
					phase2_q <= 1'b0;
					st_q <= S_DIV;
				end
				S_DIV: begin
					div_q <= div_n;
					rem_q <= rem_n;
					cnt_q <= cnt_q - 6'd1;
					if (cnt_q == 6'd1) begin
						if (!phase2_q) begin
							st_q <= S_ADJ1;
						end else if (!axis_q) begin
							nx_q <= res_v;
							axis_q <= 1'b1;
							st_q <= S_MUL;
						end else begin
							ny_q <= res_v;
							st_q <= S_EMIT;
						end
					end
				end
				S_ADJ1: begin
					a_q <= a_n;
					st_q <= S_ADJ2;
				end
				S_ADJ2: begin
					if (a_q[34] || a_q == '0 || num >= signed'(lim)) begin
						if (!axis_q) begin
							nx_q <= a_q[34] || a_q == '0 ? 16'd0 : ttsam_pkg::NORM_MAX;
							axis_q <= 1'b1;
							st_q <= S_MUL;
						end else begin
							ny_q <= a_q[34] || a_q == '0 ? 16'd0 : ttsam_pkg::NORM_MAX;
							st_q <= S_EMIT;
						end
					end else begin
						div_q <= {num[15:0], 16'b0};
						rem_q <= num[31:16];
						dsr_q <= dw;
						cnt_q <= 6'd16;
						phase2_q <= 1'b1;
						st_q <= S_DIV;
					end
				end
				S_EMIT: begin
					if (!ofull) begin
						if (mv_p_q) begin
							mv_p_q <= 1'b0;
						end else if (l_p_q) begin
							l_p_q <= 1'b0;
						end else begin
							r_p_q <= 1'b0;
						end
						if (emit_last) begin
							st_q <= S_IDLE;
						end
					end
				end
				default: st_q <= S_IDLE;
			endcase
		end
	end

`ifndef NO_ASSERTIONS
	a_pop_idle: assert property (@(posedge clk) disable iff (!arst_n)
		jpop |=> (st_q == S_MUL || st_q == S_EMIT))
		else $error("job taken without starting work");
	a_div_cnt: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == S_DIV) |-> cnt_q != 6'd0)
		else $error("divider running with no steps left");
	a_emit_pend: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == S_EMIT) |-> (mv_p_q || l_p_q || r_p_q))
		else $error("issue state with nothing pending");
	a_push_space: assert property (@(posedge clk) disable iff (!arst_n)
		opush |-> !ofull)
		else $error("result pushed into full queue");
`endif
endmodule
`default_nettype wire

// File: hdl/touch_to_screen_absolute_mapper_top.sv
// Top level of the touch-to-screen absolute mapper: registers, queues and the two parts.
//
//  Channel   Handshake               Payload
//  input     push / full             contact_id, tip_down, x/y_present, x/y_sample, keys
//  result    empty / pop             event_kind, norm_x, norm_y, pressed, last_of_run
//  config    cfg_we                  cfg_addr, cfg_data
//
// A report that gives no move goes from the job queue straight to result issue. A report
// with a move keeps the back part busy: it takes the item, then per axis runs a multiply,
// a set-up step, a 32-step quotient, an offset step and a range check, plus a 16-step
// quotient unless the point lies off the desktop, and then issues one result per cycle while
// the result queue has room; the quotients all go through the single one-bit-per-cycle divider.
// Asynchronous active-low reset clears the lock, the kept samples, the button levels and
// both queues, and loads the register defaults. The front part takes a new report while the
// back part works, until the two-entry job queue is full; results wait in their own queue.
`default_nettype none
module touch_to_screen_absolute_mapper_top #(
	parameter int COORD_BITS = ttsam_pkg::COORD_BITS_DEF,
	parameter int CONTACT_BITS = ttsam_pkg::CONTACT_BITS_DEF
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            cfg_we,
	input  wire logic [ttsam_pkg::CFG_IDX_W-1:0] cfg_addr,
	input  wire logic [ttsam_pkg::CFG_W-1:0]     cfg_data,
	input  wire logic                            push,
	output logic                                 full,
	input  wire logic [CONTACT_BITS-1:0]         contact_id,
	input  wire logic                            tip_down,
	input  wire logic                            x_present,
	input  wire logic [COORD_BITS-1:0]           x_sample,
	input  wire logic                            y_present,
	input  wire logic [COORD_BITS-1:0]           y_sample,
	input  wire logic                            left_key_down,
	input  wire logic                            right_key_down,
	output logic                                 empty,
	input  wire logic                            pop,
	output logic [1:0]                           event_kind,
	output logic [15:0]                          norm_x,
	output logic [15:0]                          norm_y,
	output logic                                 pressed,
	output logic                                 last_of_run
);
	ttsam_pkg::cfg_t cfg_q;
	ttsam_pkg::job_t job_in, job_out;
	ttsam_pkg::res_t res_in, res_out;
	logic            jpush, jfull, jpop, jempty, opush, ofull;

	// Configuration registers; writes to indexes beyond the list are dropped.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.pad_x <= ttsam_pkg::PAD_X_RST;
			cfg_q.pad_y <= ttsam_pkg::PAD_Y_RST;
			cfg_q.scr_x <= ttsam_pkg::SCR_X_RST;
			cfg_q.scr_y <= ttsam_pkg::SCR_Y_RST;
			cfg_q.desk_x <= ttsam_pkg::DESK_X_RST;
			cfg_q.desk_y <= ttsam_pkg::DESK_Y_RST;
			cfg_q.ctrl <= ttsam_pkg::CTRL_RST;
		end else if (cfg_we) begin
			case (cfg_addr)
				ttsam_pkg::REG_PAD_X:  cfg_q.pad_x <= cfg_data;
				ttsam_pkg::REG_PAD_Y:  cfg_q.pad_y <= cfg_data;
				ttsam_pkg::REG_SCR_X:  cfg_q.scr_x <= cfg_data;
				ttsam_pkg::REG_SCR_Y:  cfg_q.scr_y <= cfg_data;
				ttsam_pkg::REG_DESK_X: cfg_q.desk_x <= cfg_data;
				ttsam_pkg::REG_DESK_Y: cfg_q.desk_y <= cfg_data;
				ttsam_pkg::REG_CTRL:   cfg_q.ctrl <= cfg_data[4:0];
				default: ;
			endcase
		end
	end

	assign full = jfull;

	ttsam_front #(
		.COORD_BITS(COORD_BITS),
		.CONTACT_BITS(CONTACT_BITS)
	) u_front (
		.clk(clk),
		.arst_n(arst_n),
		.cfg(cfg_q),
		.push(push),
		.contact_id(contact_id),
		.tip_down(tip_down),
		.x_present(x_present),
		.x_sample(x_sample),
		.y_present(y_present),
		.y_sample(y_sample),
		.left_key_down(left_key_down),
		.right_key_down(right_key_down),
		.jfull(jfull),
		.jpush(jpush),
		.job(job_in)
	);

	ttsam_fifo #(.WIDTH($bits(ttsam_pkg::job_t))) u_jobq (
		.clk(clk),
		.arst_n(arst_n),
		.push(jpush),
		.wdata(job_in),
		.full(jfull),
		.pop(jpop),
		.rdata(job_out),
		.empty(jempty)
	);

	ttsam_back u_back (
		.clk(clk),
		.arst_n(arst_n),
		.cfg(cfg_q),
		.jempty(jempty),
		.jdata(job_out),
		.jpop(jpop),
		.ofull(ofull),
		.opush(opush),
		.odata(res_in)
	);

	ttsam_fifo #(.WIDTH($bits(ttsam_pkg::res_t))) u_resq (
		.clk(clk),
		.arst_n(arst_n),
		.push(opush),
		.wdata(res_in),
		.full(ofull),
		.pop(pop),
		.rdata(res_out),
		.empty(empty)
	);

	assign event_kind = res_out.kind;
	assign norm_x = res_out.nx;
	assign norm_y = res_out.ny;
	assign pressed = res_out.pressed;
	assign last_of_run = res_out.last;
endmodule
`default_nettype wire
